// File: rtl/qps_pkg.sv
// qps_pkg: shared types and constants for the qualified priority max selector
// used by every module of the block; depends on nothing
package qps_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int VOL_W      = 5;
    localparam int PRIO_W     = 8;
    localparam int BONUS_W    = 4;
    localparam int SCORE_W    = 9;
    localparam int WIDX_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_PRIORITY_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_BONUS       = 2'd2;

    localparam logic [VOL_W-1:0]   VOLUME_THRESHOLD_RST    = 5'd6;
    localparam logic [PRIO_W-1:0]  FADE_PRIORITY_FLOOR_RST = 8'd90;
    localparam logic [BONUS_W-1:0] CURRENT_BONUS_RST       = 4'd4;

    typedef enum logic [1:0] {
        ACT_KEEP   = 2'd0,
        ACT_SWITCH = 2'd1,
        ACT_NONE   = 2'd2
    } action_t;

    typedef struct packed {
        logic [VOL_W-1:0]   volume_threshold;
        logic [PRIO_W-1:0]  fade_priority_floor;
        logic [BONUS_W-1:0] current_bonus;
    } cfg_t;

    typedef struct packed {
        logic              playing;
        logic              muted;
        logic              time_nonzero;
        logic [VOL_W-1:0]  volume;
        logic [PRIO_W-1:0] priority_req;
        logic              is_current;
        logic              fade_active;
        logic              area_drawn;
        logic              last_entry;
    } item_t;

endpackage

// File: rtl/qps_score.sv
// qps_score: qualification check and score of one registered entry
// depends on qps_pkg
module qps_score (
    input  qps_pkg::item_t               item,
    input  qps_pkg::cfg_t                cfg,
    output logic [qps_pkg::SCORE_W-1:0]  score
);
    import qps_pkg::*;

    logic               disq;
    logic [SCORE_W-1:0] base;
    logic [SCORE_W-1:0] bonus;

    always_comb
    begin
        disq = !item.playing || item.muted || !item.time_nonzero
               || (item.volume < cfg.volume_threshold)
               || (item.fade_active && (item.priority_req < cfg.fade_priority_floor));
        base  = SCORE_W'(item.priority_req) + SCORE_W'(item.volume);
        bonus = item.is_current ? SCORE_W'(cfg.current_bonus) : '0;
        score = disq ? '0 : (base + bonus);
    end

endmodule

// File: rtl/qps_track.sv
// qps_track: running best of a scan and the result register
// depends on qps_pkg
module qps_track #(
    parameter int MAX_ENTRIES = qps_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic [qps_pkg::SCORE_W-1:0]   score,
    input  logic                          is_current,
    input  logic                          area_drawn,
    input  logic                          last_entry,
    output logic                          take,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          winner_valid,
    output logic [qps_pkg::WIDX_W-1:0]    winner_index,
    output logic [qps_pkg::SCORE_W-1:0]   winner_score,
    output logic [1:0]                    action,
    output logic                          clear_area
);
    import qps_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [IW-1:0]      best_index_reg, best_index_next;
    logic               best_is_current_reg, best_is_current_next;
    logic               current_seen_reg, current_seen_next;
    logic [CW-1:0]      entry_count_reg, entry_count_next;

    logic               res_valid_reg, res_valid_next;
    logic               res_winner_reg;
    logic [WIDX_W-1:0]  res_index_reg;
    logic [SCORE_W-1:0] res_score_reg;
    action_t            res_action_reg;
    logic               res_clear_reg;

    logic               in_range;
    logic               better;
    logic [SCORE_W-1:0] upd_score;
    logic [IW-1:0]      upd_index;
    logic               upd_is_current;
    logic               upd_seen;
    logic [IW+WIDX_W-1:0] index_ext;
    logic               emit;

    always_comb
    begin
        take      = item_valid && (!last_entry || !res_valid_reg || !out_stall);
        emit      = take && last_entry;
        in_range  = entry_count_reg < CW'(MAX_ENTRIES);
        better    = in_range && (score > best_score_reg);
        upd_score      = better ? score : best_score_reg;
        upd_index      = better ? entry_count_reg[IW-1:0] : best_index_reg;
        upd_is_current = better ? is_current : best_is_current_reg;
        upd_seen       = current_seen_reg | is_current;
        index_ext      = {{WIDX_W{1'b0}}, upd_index};
    end

    always_comb
    begin
        best_score_next      = best_score_reg;
        best_index_next      = best_index_reg;
        best_is_current_next = best_is_current_reg;
        current_seen_next    = current_seen_reg;
        entry_count_next     = entry_count_reg;
        if (take)
        begin
            if (last_entry)
            begin
                best_score_next      = '0;
                best_index_next      = '0;
                best_is_current_next = 1'b0;
                current_seen_next    = 1'b0;
                entry_count_next     = '0;
            end
            else
            begin
                best_score_next      = upd_score;
                best_index_next      = upd_index;
                best_is_current_next = upd_is_current;
                current_seen_next    = upd_seen;
                entry_count_next     = in_range ? entry_count_reg + CW'(1) : entry_count_reg;
            end
        end
        res_valid_next = emit || (res_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg      <= '0;
            best_index_reg      <= '0;
            best_is_current_reg <= 1'b0;
            current_seen_reg    <= 1'b0;
            entry_count_reg     <= '0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            best_score_reg      <= best_score_next;
            best_index_reg      <= best_index_next;
            best_is_current_reg <= best_is_current_next;
            current_seen_reg    <= current_seen_next;
            entry_count_reg     <= entry_count_next;
            res_valid_reg       <= res_valid_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (upd_score != '0)
            begin
                res_winner_reg <= 1'b1;
                res_index_reg  <= index_ext[WIDX_W-1:0];
                res_score_reg  <= upd_score;
                if (upd_is_current)
                begin
                    res_action_reg <= ACT_KEEP;
                    res_clear_reg  <= 1'b0;
                end
                else
                begin
                    res_action_reg <= ACT_SWITCH;
                    res_clear_reg  <= area_drawn;
                end
            end
            else
            begin
                res_winner_reg <= 1'b0;
                res_index_reg  <= '0;
                res_score_reg  <= '0;
                res_action_reg <= ACT_NONE;
                res_clear_reg  <= upd_seen && area_drawn;
            end
        end
    end

    assign out_valid    = res_valid_reg;
    assign winner_valid = res_winner_reg;
    assign winner_index = res_index_reg;
    assign winner_score = res_score_reg;
    assign action       = res_action_reg;
    assign clear_area   = res_clear_reg;

endmodule

// File: rtl/qualified_priority_max_selector.sv
// qualified_priority_max_selector: top level with config registers and input register
// depends on qps_pkg, qps_score, qps_track
//
// Takes one candidate entry per beat and gives one result beat when the entry
// marked last_entry has been taken. Each entry goes input register -> score and
// compare -> scan state / result register; a scan's result is registered when its
// last entry is taken from the input register. The block sustains one entry per
// cycle; only a full, stalled result register holds back input, and only a last
// entry waits for it. Entries beyond MAX_ENTRIES in a scan are left out of selection.
// The user writes configuration via cfg_wr_en only while idle; it is not enforced.
module qualified_priority_max_selector #(
    parameter int MAX_ENTRIES = qps_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [qps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            playing,
    input  logic                            muted,
    input  logic                            time_nonzero,
    input  logic [qps_pkg::VOL_W-1:0]       volume,
    input  logic [qps_pkg::PRIO_W-1:0]      priority_req,
    input  logic                            is_current,
    input  logic                            fade_active,
    input  logic                            area_drawn,
    input  logic                            last_entry,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            winner_valid,
    output logic [qps_pkg::WIDX_W-1:0]      winner_index,
    output logic [qps_pkg::SCORE_W-1:0]     winner_score,
    output logic [1:0]                      action,
    output logic                            clear_area
);
    import qps_pkg::*;

    cfg_t               cfg_reg;
    logic               item_valid_reg, item_valid_next;
    item_t              item_reg;
    logic               take;
    logic               accept;
    logic [SCORE_W-1:0] score;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume_threshold    <= VOLUME_THRESHOLD_RST;
            cfg_reg.fade_priority_floor <= FADE_PRIORITY_FLOOR_RST;
            cfg_reg.current_bonus       <= CURRENT_BONUS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_VOLUME_THRESHOLD:    cfg_reg.volume_threshold    <= cfg_data[VOL_W-1:0];
                REG_FADE_PRIORITY_FLOOR: cfg_reg.fade_priority_floor <= cfg_data[PRIO_W-1:0];
                REG_CURRENT_BONUS:       cfg_reg.current_bonus       <= cfg_data[BONUS_W-1:0];
                default:                 cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    assign in_stall = item_valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = accept || (item_valid_reg && !take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // input beat register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.playing      <= playing;
            item_reg.muted        <= muted;
            item_reg.time_nonzero <= time_nonzero;
            item_reg.volume       <= volume;
            item_reg.priority_req <= priority_req;
            item_reg.is_current   <= is_current;
            item_reg.fade_active  <= fade_active;
            item_reg.area_drawn   <= area_drawn;
            item_reg.last_entry   <= last_entry;
        end
    end

    qps_score u_score (
        .item  (item_reg),
        .cfg   (cfg_reg),
        .score (score)
    );

    qps_track #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid_reg),
        .score        (score),
        .is_current   (item_reg.is_current),
        .area_drawn   (item_reg.area_drawn),
        .last_entry   (item_reg.last_entry),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .winner_valid (winner_valid),
        .winner_index (winner_index),
        .winner_score (winner_score),
        .action       (action),
        .clear_area   (clear_area)
    );

endmodule

// File: verif/qualified_priority_max_selector_tb.sv
`timescale 1ns / 1ps
// qualified_priority_max_selector_tb: self-checking testbench for the qualified priority max selector
// scores each accepted entry in a local scan tracker and checks every result beat against it
// depends on qps_pkg and the qualified_priority_max_selector rtl only
module qualified_priority_max_selector_tb;
    import qps_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int ITEM_W        = $bits(item_t);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic                wv;
        logic [WIDX_W-1:0]   idx;
        logic [SCORE_W-1:0]  score;
        action_t             act;
        logic                clr;
    } winner_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    item_t                 entry_bus = '0;
    logic                  out_valid;
    logic                  out_stall;
    logic                  winner_valid;
    logic [WIDX_W-1:0]     winner_index;
    logic [SCORE_W-1:0]    winner_score;
    logic [1:0]            action;
    logic                  clear_area;

    logic rx_pause = 1'b0;
    logic rx_hold = 1'b0;
    int   rx_wait = 0;
    int   hold_len = 0;
    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;

    int cycles = 0;
    int mismatches = 0;
    int entries_taken = 0;
    int scans_checked = 0;

    // local copy of the registers and the running scan
    logic [VOL_W-1:0]   thr_cfg = VOLUME_THRESHOLD_RST;
    logic [PRIO_W-1:0]  floor_cfg = FADE_PRIORITY_FLOOR_RST;
    logic [BONUS_W-1:0] bonus_cfg = CURRENT_BONUS_RST;
    int unsigned        run_best_score = 0;
    int unsigned        run_best_idx = 0;
    bit                 run_best_cur = 1'b0;
    bit                 run_cur_seen = 1'b0;
    int unsigned        run_count = 0;
    winner_t            winner_q[$];

    assign out_stall = rx_pause | rx_hold;

    qualified_priority_max_selector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .playing      (entry_bus.playing),
        .muted        (entry_bus.muted),
        .time_nonzero (entry_bus.time_nonzero),
        .volume       (entry_bus.volume),
        .priority_req (entry_bus.priority_req),
        .is_current   (entry_bus.is_current),
        .fade_active  (entry_bus.fade_active),
        .area_drawn   (entry_bus.area_drawn),
        .last_entry   (entry_bus.last_entry),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .winner_valid (winner_valid),
        .winner_index (winner_index),
        .winner_score (winner_score),
        .action       (action),
        .clear_area   (clear_area)
    );

    always #10 clk = ~clk;

    function automatic void track_entry(input item_t e);
        int unsigned score;
        bit          disq;
        winner_t     w;
        disq = !e.playing || e.muted || !e.time_nonzero || e.volume < thr_cfg ||
               (e.fade_active && e.priority_req < floor_cfg);
        score = 0;
        if (!disq)
        begin
            score = e.priority_req + e.volume;
            if (e.is_current)
                score += bonus_cfg;
        end
        if (e.is_current)
            run_cur_seen = 1'b1;
        if (run_count < MAX_ENTRIES_DEF)
        begin
            if (score > run_best_score)
            begin
                run_best_score = score;
                run_best_idx = run_count;
                run_best_cur = e.is_current;
            end
            run_count++;
        end
        if (e.last_entry)
        begin
            if (run_best_score != 0)
            begin
                w.wv = 1'b1;
                w.idx = run_best_idx[WIDX_W-1:0];
                w.score = run_best_score[SCORE_W-1:0];
                if (run_best_cur)
                begin
                    w.act = ACT_KEEP;
                    w.clr = 1'b0;
                end
                else
                begin
                    w.act = ACT_SWITCH;
                    w.clr = e.area_drawn;
                end
            end
            else
            begin
                w.wv = 1'b0;
                w.idx = '0;
                w.score = '0;
                w.act = ACT_NONE;
                w.clr = run_cur_seen && e.area_drawn;
            end
            winner_q.push_back(w);
            run_best_score = 0;
            run_best_idx = 0;
            run_best_cur = 1'b0;
            run_cur_seen = 1'b0;
            run_count = 0;
        end
    endfunction

    // input beats
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            track_entry(entry_bus);
            entries_taken++;
        end
    end

    // result beats
    always @(posedge clk)
    begin : result_check
        winner_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (winner_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat at cycle %0d", cycles);
            end
            else
            begin
                w = winner_q.pop_front();
                scans_checked++;
                if (winner_valid !== w.wv || winner_index !== w.idx ||
                    winner_score !== w.score || action !== w.act || clear_area !== w.clr)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("scan %0d: expected valid %0b index %0d score %0d action %0d clear %0b",
                                 scans_checked, w.wv, w.idx, w.score, w.act, w.clr);
                        $display("    got valid %0b index %0d score %0d action %0d clear %0b",
                                 winner_valid, winner_index, winner_score, action, clear_area);
                    end
                end
            end
        end
    end

    // receiver pacing, a fresh wait drawn after every beat
    always @(posedge clk)
    begin : rx_pacing
        int n;
        if (out_valid && !out_stall)
        begin
            n = rx_idle_on ? $urandom_range(0, 10) : 0;
            rx_wait <= n;
            rx_pause <= (n != 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            rx_pause <= (rx_wait > 1);
        end
    end

    // long receiver hold
    initial
    begin
        forever
        begin
            wait (hold_len > 0);
            rx_hold <= 1'b1;
            repeat (hold_len) @(posedge clk);
            rx_hold <= 1'b0;
            hold_len = 0;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d scans pending", cycles, winner_q.size());
        $display("qualified_priority_max_selector_tb: done, errors");
        $finish;
    end

    function automatic item_t mk_entry(input logic pl, input logic mu, input logic tn,
                                       input logic [VOL_W-1:0] vol,
                                       input logic [PRIO_W-1:0] pr, input logic cur,
                                       input logic fd, input logic drawn,
                                       input logic is_last);
        item_t e;
        e.playing = pl;
        e.muted = mu;
        e.time_nonzero = tn;
        e.volume = vol;
        e.priority_req = pr;
        e.is_current = cur;
        e.fade_active = fd;
        e.area_drawn = drawn;
        e.last_entry = is_last;
        return e;
    endfunction

    // mostly plausible entries, scores bunched near the floor and in a tie band
    function automatic item_t rand_entry(input bit is_last);
        item_t e;
        if ($urandom_range(0, 9) == 0)
            e = item_t'(ITEM_W'($urandom()));
        else
        begin
            e.playing = ($urandom_range(0, 7) != 0);
            e.muted = ($urandom_range(0, 7) == 0);
            e.time_nonzero = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 3) == 0)
                e.volume = VOL_W'(thr_cfg + $urandom_range(0, 1));
            else
                e.volume = VOL_W'($urandom_range(0, 31));
            case ($urandom_range(0, 3))
                0: e.priority_req = PRIO_W'(floor_cfg - 8'd1 + $urandom_range(0, 2));
                1: e.priority_req = PRIO_W'(8'd120 + $urandom_range(0, 2));
                default: e.priority_req = PRIO_W'($urandom_range(0, 255));
            endcase
            e.is_current = ($urandom_range(0, 4) == 0);
            e.fade_active = ($urandom_range(0, 2) == 0);
            e.area_drawn = ($urandom_range(0, 1) != 0);
        end
        e.last_entry = is_last;
        return e;
    endfunction

    function automatic int pick_scan_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(14, 20);
        return $urandom_range(1, 6);
    endfunction

    task automatic send_entry(input item_t e);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        entry_bus <= e;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_scan(input int len);
        for (int i = 0; i < len; i++)
            send_entry(rand_entry(i == len - 1));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (winner_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_VOLUME_THRESHOLD:    thr_cfg = data[VOL_W-1:0];
            REG_FADE_PRIORITY_FLOOR: floor_cfg = data;
            REG_CURRENT_BONUS:       bonus_cfg = data[BONUS_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] flr,
                              input logic [CFG_DATA_W-1:0] bonus);
        write_reg(REG_VOLUME_THRESHOLD, thr);
        write_reg(REG_FADE_PRIORITY_FLOOR, flr);
        write_reg(REG_CURRENT_BONUS, bonus);
    endtask

    task automatic test_reset_values();
        // winner at the volume threshold
        send_entry(mk_entry(1, 0, 1, 5'd6, 8'd0, 0, 0, 1, 1));
        // nothing qualifies, no holder seen
        send_entry(mk_entry(1, 0, 1, 5'd5, 8'd200, 0, 0, 0, 0));
        send_entry(mk_entry(1, 1, 1, 5'd31, 8'd200, 0, 0, 1, 1));
        // nothing qualifies, holder seen
        send_entry(mk_entry(0, 0, 1, 5'd31, 8'd255, 1, 0, 0, 0));
        send_entry(mk_entry(1, 0, 0, 5'd31, 8'd255, 0, 0, 0, 0));
        send_entry(mk_entry(1, 0, 1, 5'd31, 8'd89, 0, 1, 1, 1));
        // equal scores, first one wins; fade at the floor qualifies
        send_entry(mk_entry(1, 0, 1, 5'd31, 8'd90, 0, 1, 0, 0));
        send_entry(mk_entry(1, 0, 1, 5'd6, 8'd111, 1, 0, 0, 1));
        // two holders, top score kept
        send_entry(mk_entry(1, 0, 1, 5'd31, 8'd255, 1, 1, 1, 0));
        send_entry(mk_entry(1, 0, 1, 5'd31, 8'd255, 1, 0, 1, 1));
        drain();
    endtask

    task automatic test_register_extremes();
        set_config(8'd0, 8'd255, 8'd15);
        send_entry(mk_entry(1, 0, 1, 5'd0, 8'd0, 0, 0, 1, 1));
        send_entry(mk_entry(1, 0, 1, 5'd0, 8'd254, 1, 1, 1, 0));
        send_entry(mk_entry(1, 0, 1, 5'd31, 8'd255, 1, 1, 1, 1));
        drain();
        // upper data bits beyond the register width are dropped
        write_reg(REG_VOLUME_THRESHOLD, 8'hff);
        write_reg(REG_FADE_PRIORITY_FLOOR, 8'h00);
        write_reg(REG_CURRENT_BONUS, 8'hf0);
        write_reg(REG_SPARE, 8'ha5);
        send_entry(mk_entry(1, 0, 1, 5'd30, 8'd255, 0, 0, 1, 0));
        send_entry(mk_entry(1, 0, 1, 5'd31, 8'd0, 1, 1, 1, 1));
        drain();
    endtask

    task automatic test_entry_overflow();
        logic [PRIO_W-1:0] pr;
        set_config(CFG_DATA_W'(VOLUME_THRESHOLD_RST), FADE_PRIORITY_FLOOR_RST,
                   CFG_DATA_W'(CURRENT_BONUS_RST));
        // positions past the limit carry the top score but must be ignored
        for (int i = 0; i <= MAX_ENTRIES_DEF; i++)
        begin
            pr = (i == MAX_ENTRIES_DEF - 1) ? 8'd200 :
                 (i >= MAX_ENTRIES_DEF) ? 8'd255 : 8'(10 + i);
            send_entry(mk_entry(1, 0, 1, 5'd6, pr, 0, 0, 1, i == MAX_ENTRIES_DEF));
        end
        drain();
    endtask

    task automatic test_receiver_hold();
        int start;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_len = 120;
        start = entries_taken;
        while (entries_taken - start < 40)
            send_scan($urandom_range(1, 2));
        drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_scans();
        int sent;
        int len;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_config(CFG_DATA_W'(VOLUME_THRESHOLD_RST), FADE_PRIORITY_FLOOR_RST,
                              CFG_DATA_W'(CURRENT_BONUS_RST));
                1: set_config(8'd0, 8'd0, 8'd0);
                2: set_config(8'd31, 8'd255, 8'd15);
                default: set_config(CFG_DATA_W'($urandom_range(0, 12)),
                                    CFG_DATA_W'($urandom_range(0, 255)),
                                    CFG_DATA_W'($urandom_range(0, 15)));
            endcase
            tx_idle_on = (phase % 3 != 1);
            rx_idle_on = (phase % 2 == 0);
            sent = 0;
            while (sent < 90)
            begin
                len = pick_scan_len();
                send_scan(len);
                sent += len;
            end
            // sender waits for every result before the next setting
            drain();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_register_extremes();
        test_entry_overflow();
        test_receiver_hold();
        test_random_scans();
        drain();
        $display("%0d entries in %0d scans over reset, extreme and random register values",
                 entries_taken, scans_checked);
        $display("random idling, long output hold with input back-pressure, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && winner_q.size() == 0)
            $display("qualified_priority_max_selector_tb: done, clean");
        else
            $display("qualified_priority_max_selector_tb: done, errors");
        $finish;
    end

endmodule

// File: qualified_priority_max_selector.f
rtl/qps_pkg.sv
rtl/qps_score.sv
rtl/qps_track.sv
rtl/qualified_priority_max_selector.sv
verif/qualified_priority_max_selector_tb.sv
